// File: rtl/vdfl_pkg.sv
// Shared types, constants and helpers for the descriptor free list.
package vdfl_pkg;

	localparam int IDX_W    = 8;
	localparam int CNT_W    = 9;
	localparam int MAX_DESC = 256;

	localparam logic [2:0] OP_ALLOC   = 3'd0;
	localparam logic [2:0] OP_FREE    = 3'd1;
	localparam logic [2:0] OP_CHAIN   = 3'd2;
	localparam logic [2:0] OP_SETLINK = 3'd3;
	localparam logic [2:0] OP_REINIT  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_CUT   = 2'd3;

	typedef struct packed {
		logic             indirect;
		logic             has_next;
		logic [IDX_W-1:0] next;
	} link_t;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic             refill;
		logic [CNT_W-1:0] refill_size;
		logic [IDX_W-1:0] data;
	} stk_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] top;
		logic             full;
		logic             empty;
		logic [IDX_W-1:0] rd_data;
	} stk_sts_t;

	// Clamp a queue size to 1..MAX_DESC.
	function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] q);
		logic [CNT_W-1:0] r;
		r = q;
		if (q == '0) begin
			r = CNT_W'(1);
		end else if (q > CNT_W'(MAX_DESC)) begin
			r = CNT_W'(MAX_DESC);
		end
		return r;
	endfunction

endpackage

// File: rtl/vdfl_if.sv
// Request and response channel interfaces of the descriptor free list.
interface vdfl_req_if import vdfl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [2:0]       opcode;
	logic [IDX_W-1:0] desc_index;
	logic             link_has_next;
	logic             link_indirect;
	logic [IDX_W-1:0] link_next;

	modport source (output valid, opcode, desc_index, link_has_next, link_indirect,
		link_next, input ready);
	modport sink (input valid, opcode, desc_index, link_has_next, link_indirect,
		link_next, output ready);
endinterface

interface vdfl_rsp_if import vdfl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [IDX_W-1:0] alloc_index;
	logic [CNT_W-1:0] freed_count;
	logic [CNT_W-1:0] free_level;

	modport source (output valid, status, alloc_index, freed_count, free_level,
		input ready);
	modport sink (input valid, status, alloc_index, freed_count, free_level,
		output ready);
endinterface

// File: rtl/vdfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vdfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/vdfl_stack.sv
// Free index stack: pointer unit with one shared adder, RAM and lazy refill.
module vdfl_stack import vdfl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  stk_cmd_t         cmd,
	input  logic [CNT_W-1:0] asize,
	output stk_sts_t         sts
);

	logic [CNT_W-1:0] top_q;
	// Positions below min_q still hold their refill value (size-1-pos)
	logic [CNT_W-1:0] min_q;
	logic             virt_q;
	logic [IDX_W-1:0] virt_val_q;
	logic [CNT_W-1:0] top_adj;
	logic [CNT_W-1:0] virt_diff;
	logic             full;
	logic             empty;
	logic             do_push;
	logic             do_pop;
	logic [IDX_W-1:0] ram_rdata;

	assign full      = top_q >= asize;
	assign empty     = top_q == '0;
	assign do_push   = cmd.push && !full;
	assign do_pop    = cmd.pop && !empty;
	// Shared pointer adder: up on push, down otherwise
	assign top_adj   = cmd.push ? top_q + CNT_W'(1) : top_q - CNT_W'(1);
	assign virt_diff = asize - top_q;

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= CNT_W'(MAX_DESC);
			min_q <= CNT_W'(MAX_DESC);
		end else if (cmd.refill) begin
			top_q <= cmd.refill_size;
			min_q <= cmd.refill_size;
		end else if (do_push) begin
			top_q <= top_adj;
		end else if (do_pop) begin
			top_q <= top_adj;
			if (top_q == min_q) begin
				min_q <= top_adj;
			end
		end
	end

	// Hold the refill value for a pop from an untouched position
	always_ff @(posedge clk) begin
		if (do_pop) begin
			virt_q     <= top_q == min_q;
			virt_val_q <= virt_diff[IDX_W-1:0];
		end
	end

	vdfl_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_DESC)
	) u_stack_ram (
		.clk  (clk),
		.we   (do_push),
		.waddr(top_q[IDX_W-1:0]),
		.wdata(cmd.data),
		.re   (do_pop),
		.raddr(top_adj[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign sts.top     = top_q;
	assign sts.full    = full;
	assign sts.empty   = empty;
	assign sts.rd_data = virt_q ? virt_val_q : ram_rdata;

endmodule

// File: rtl/virtqueue_descriptor_free_list_top.sv
// Top level of the virtqueue descriptor free list.
//
// Usage: requests arrive on the req channel (valid/ready), one response per
// request leaves on the rsp channel from an output register. A request is
// taken only while the sequencer is idle; it then runs to completion.
// Path from accept to response: alloc runs through EXEC, POPW and DONE (EXEC
// and DONE on an empty stack); free, set link, reinit and unknown opcodes run
// through EXEC and DONE; free chain runs through EXEC, one LINKEV per link
// (one link table read per link, bounded by the queue size) and DONE.
// DONE loads the output register.
// The next request is taken in the cycle after the response is loaded, even
// if the receiver has not yet taken it; a finished response waits in the
// sequencer while the output register is still occupied.
// Reset: queue size 256, stack full with index 0 on top, no response valid.
// The stack refill needs no clearing pass: untouched positions read as their
// refill value. Writing cfg_wdata (queue size) refills the stack at once;
// write only while no request is in flight.
module virtqueue_descriptor_free_list_top import vdfl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	vdfl_req_if.sink         req,
	vdfl_rsp_if.source       rsp
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_POPW   = 3'd2;
	localparam logic [2:0] S_LINKEV = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       state_nxt;
	logic [CNT_W-1:0] queue_size_q;
	logic [CNT_W-1:0] asize;

	logic [2:0]       op_q;
	logic [IDX_W-1:0] idx_q;
	link_t            wlink_q;
	logic             first_q;
	logic             dropped_q;
	logic [CNT_W-1:0] steps_q;
	logic [CNT_W-1:0] steps_nxt;
	logic [1:0]       status_q;
	logic [IDX_W-1:0] alloc_q;
	logic [CNT_W-1:0] freed_q;

	logic             out_valid_q;
	logic             out_free;
	logic             accept;

	stk_cmd_t         stk_cmd;
	stk_sts_t         stk_sts;

	logic             link_re;
	logic [IDX_W-1:0] link_raddr;
	logic             link_we;
	logic [2+IDX_W-1:0] link_rbits;
	link_t            link_rd;
	logic             chain_cont;

	assign asize     = clamp_size(queue_size_q);
	assign accept    = req.valid && req.ready;
	assign req.ready = state_q == S_IDLE;
	assign out_free  = !out_valid_q || rsp.ready;
	assign link_rd   = link_t'(link_rbits);
	assign steps_nxt = steps_q + CNT_W'(1);

	// Continue the chain walk: not indirect head, has next, below bound
	assign chain_cont = !(first_q && link_rd.indirect) && link_rd.has_next &&
		(steps_nxt != asize);

	// Queue size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_size_q <= CNT_W'(MAX_DESC);
		end else if (cfg_we) begin
			queue_size_q <= cfg_wdata;
		end
	end

	// Stack commands
	always_comb begin
		stk_cmd             = '0;
		stk_cmd.data        = idx_q;
		stk_cmd.refill_size = cfg_we ? clamp_size(cfg_wdata) : asize;
		stk_cmd.refill      = cfg_we || (state_q == S_EXEC && op_q == OP_REINIT);
		if (state_q == S_EXEC) begin
			stk_cmd.pop  = op_q == OP_ALLOC;
			stk_cmd.push = op_q == OP_FREE;
		end else if (state_q == S_LINKEV) begin
			stk_cmd.push = 1'b1;
		end
	end

	// Link table port control
	always_comb begin
		link_we    = state_q == S_EXEC && op_q == OP_SETLINK;
		link_re    = 1'b0;
		link_raddr = idx_q;
		if (state_q == S_EXEC) begin
			link_re = op_q == OP_CHAIN;
		end else if (state_q == S_LINKEV) begin
			link_re    = chain_cont;
			link_raddr = link_rd.next;
		end
	end

	// Sequencer next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (op_q == OP_ALLOC && !stk_sts.empty) begin
					state_nxt = S_POPW;
				end else if (op_q == OP_CHAIN) begin
					state_nxt = S_LINKEV;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_POPW: begin
				state_nxt = S_DONE;
			end
			S_LINKEV: begin
				if (!chain_cont) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Request capture and result accumulation
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q             <= req.opcode;
					idx_q            <= req.desc_index;
					wlink_q.indirect <= req.link_indirect;
					wlink_q.has_next <= req.link_has_next;
					wlink_q.next     <= req.link_next;
					status_q         <= ST_OK;
					alloc_q          <= '0;
					freed_q          <= '0;
					dropped_q        <= 1'b0;
					steps_q          <= '0;
					first_q          <= 1'b1;
				end
			end
			S_EXEC: begin
				if (op_q == OP_ALLOC && stk_sts.empty) begin
					status_q <= ST_EMPTY;
				end else if (op_q == OP_FREE) begin
					if (stk_sts.full) begin
						status_q <= ST_FULL;
					end else begin
						freed_q <= CNT_W'(1);
					end
				end
			end
			S_POPW: begin
				alloc_q <= stk_sts.rd_data;
			end
			S_LINKEV: begin
				// Push this link, then end, cut or follow next
				if (!stk_sts.full) begin
					freed_q <= freed_q + CNT_W'(1);
				end
				first_q   <= 1'b0;
				steps_q   <= steps_nxt;
				dropped_q <= dropped_q || stk_sts.full;
				idx_q     <= link_rd.next;
				if (first_q && link_rd.indirect) begin
					status_q <= stk_sts.full ? ST_FULL : ST_OK;
				end else if (!link_rd.has_next) begin
					status_q <= (dropped_q || stk_sts.full) ? ST_FULL : ST_OK;
				end else if (steps_nxt == asize) begin
					status_q <= ST_CUT;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Output register: load on completion, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp.status      <= status_q;
			rsp.alloc_index <= alloc_q;
			rsp.freed_count <= freed_q;
			rsp.free_level  <= stk_sts.top;
		end
	end

	assign rsp.valid = out_valid_q;

	vdfl_stack u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (stk_cmd),
		.asize (asize),
		.sts   (stk_sts)
	);

	vdfl_ram #(
		.WIDTH(2 + IDX_W),
		.DEPTH(MAX_DESC)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(idx_q),
		.wdata(wlink_q),
		.re   (link_re),
		.raddr(link_raddr),
		.rdata(link_rbits)
	);

endmodule

// File: rtl/vdfl_checker.sv
// Port-level checks of the descriptor free list, bound to the top level.
module vdfl_checker import vdfl_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [1:0]       rsp_status,
	input logic [IDX_W-1:0] rsp_alloc_index,
	input logic [CNT_W-1:0] rsp_freed_count,
	input logic [CNT_W-1:0] rsp_free_level
);

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_alloc_index) && $stable(rsp_freed_count) &&
		$stable(rsp_free_level))
		else $error("response changed while stalled");

	// One request in flight: no accept right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// Empty alloc leaves nothing free and gives nothing
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_alloc_index == '0 &&
		rsp_freed_count == '0 && rsp_free_level == '0)
		else $error("empty status with inconsistent fields");

	// A dropped push means the stack is not empty
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_free_level != '0 &&
		rsp_alloc_index == '0)
		else $error("full status with inconsistent fields");

	// Pushed descriptors count toward the free level
	a_freed_le_level: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_freed_count <= rsp_free_level)
		else $error("freed count exceeds free level");

endmodule

bind virtqueue_descriptor_free_list_top vdfl_checker u_vdfl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_alloc_index(rsp.alloc_index),
	.rsp_freed_count(rsp.freed_count),
	.rsp_free_level (rsp.free_level)
);

// File: sim/vdfl_free_list_checker.sv
// Checker for the descriptor free list: predicts each response and compares it with the block.
module vdfl_free_list_checker import vdfl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	vdfl_req_if              req,
	vdfl_rsp_if              rsp,
	output int unsigned      fail_count,
	output int unsigned      pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] alloc_index;
		logic [CNT_W-1:0] freed_count;
		logic [CNT_W-1:0] free_level;
	} free_list_rsp_t;

	// Predicted state of the block
	logic [CNT_W-1:0] size_cfg;
	logic [IDX_W-1:0] stack_mem [MAX_DESC];
	logic [CNT_W-1:0] stack_top;
	link_t            link_mem [MAX_DESC];

	free_list_rsp_t   expected_rsp [$];
	free_list_rsp_t   predicted;
	free_list_rsp_t   oldest;

	initial begin
		fail_count = 0;
		pending_count = 0;
	end

	function automatic int unsigned active_size();
		if (size_cfg == '0) begin
			return 1;
		end
		if (size_cfg > CNT_W'(MAX_DESC)) begin
			return MAX_DESC;
		end
		return size_cfg;
	endfunction

	function automatic void refill_stack();
		int unsigned q;
		q = active_size();
		for (int unsigned i = 0; i < q; i++) begin
			stack_mem[i] = IDX_W'(q - 1 - i);
		end
		stack_top = CNT_W'(q);
	endfunction

	// Push one index; report whether it was taken.
	function automatic bit push_desc(input logic [IDX_W-1:0] v);
		if (stack_top >= CNT_W'(active_size()) || stack_top >= CNT_W'(MAX_DESC)) begin
			return 1'b0;
		end
		stack_mem[stack_top[IDX_W-1:0]] = v;
		stack_top = stack_top + 1'b1;
		return 1'b1;
	endfunction

	// Apply one request to the predicted state and work out its response.
	task automatic predict_request(output free_list_rsp_t r);
		int unsigned      q;
		int unsigned      steps;
		logic [IDX_W-1:0] idx;
		link_t            ent;
		bit               dropped;
		bit               done;
		r = '0;
		q = active_size();
		idx = req.desc_index;
		dropped = 1'b0;
		done = 1'b0;
		case (req.opcode)
			OP_ALLOC: begin
				if (stack_top == '0) begin
					r.status = ST_EMPTY;
				end else begin
					stack_top = stack_top - 1'b1;
					r.alloc_index = stack_mem[stack_top[IDX_W-1:0]];
				end
			end
			OP_FREE: begin
				if (push_desc(idx)) begin
					r.freed_count = 1;
				end else begin
					r.status = ST_FULL;
				end
			end
			OP_CHAIN: begin
				if (link_mem[idx].indirect) begin
					// indirect head goes back alone
					if (push_desc(idx)) begin
						r.freed_count = 1;
					end else begin
						r.status = ST_FULL;
					end
				end else begin
					// walk the links, bounded by the queue size
					for (steps = 0; steps < q && !done; steps++) begin
						ent = link_mem[idx];
						if (push_desc(idx)) begin
							r.freed_count = r.freed_count + 1'b1;
						end else begin
							dropped = 1'b1;
						end
						if (!ent.has_next) begin
							done = 1'b1;
						end else begin
							idx = ent.next;
						end
					end
					if (!done) begin
						r.status = ST_CUT;
					end else if (dropped) begin
						r.status = ST_FULL;
					end
				end
			end
			OP_SETLINK: begin
				link_mem[idx] = '{indirect: req.link_indirect, has_next: req.link_has_next,
					next: req.link_next};
			end
			OP_REINIT: begin
				refill_stack();
			end
			default: begin
			end
		endcase
		r.free_level = stack_top;
	endtask

	task automatic check_field(input string what, input int unsigned exp,
		input int unsigned got);
		if (exp != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp, got);
			fail_count++;
		end
	endtask

	// Track config writes, predict on request transfers, compare on response transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg = CNT_W'(MAX_DESC);
			for (int i = 0; i < MAX_DESC; i++) begin
				link_mem[i] = '0;
			end
			refill_stack();
			expected_rsp.delete();
		end else begin
			if (cfg_we) begin
				size_cfg = cfg_wdata;
				refill_stack();
			end
			if (req.valid && req.ready) begin
				predict_request(predicted);
				expected_rsp.push_back(predicted);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t ns: response with nothing expected, status %0d level %0d",
						$time, rsp.status, rsp.free_level);
					fail_count++;
				end else begin
					oldest = expected_rsp.pop_front();
					check_field("status", oldest.status, rsp.status);
					check_field("alloc_index", oldest.alloc_index, rsp.alloc_index);
					check_field("freed_count", oldest.freed_count, rsp.freed_count);
					check_field("free_level", oldest.free_level, rsp.free_level);
				end
			end
		end
		pending_count = expected_rsp.size();
	end

endmodule

// File: sim/tb.sv
// Testbench top: drives requests and queue size writes into the free list and gives the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vdfl_pkg::*;

	localparam int unsigned      STALL_LIMIT = 2000;
	localparam logic [2:0]       OP_TOP_CODE = 3'd7;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	int unsigned      fail_count;
	int unsigned      pending_count;

	// Stimulus-side view of the link table, so no chain reads an unwritten entry
	link_t            link_shadow [MAX_DESC];
	bit               link_known [MAX_DESC];
	int unsigned      active_q = MAX_DESC;
	int unsigned      items_sent = 0;
	bit               calm = 1'b0;
	int unsigned      stall_left = 0;
	int unsigned      quiet_cycles = 0;

	vdfl_req_if req_ch ();
	vdfl_rsp_if rsp_ch ();

	virtqueue_descriptor_free_list_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	vdfl_free_list_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Response side: random stall bursts, none once calm
	always @(posedge clk) begin
		if (calm) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left != 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [IDX_W-1:0] rnd_idx();
		return IDX_W'($urandom_range(0, MAX_DESC - 1));
	endfunction

	// Present one request and hold it until the transfer.
	task automatic issue(input logic [2:0] op, input logic [IDX_W-1:0] idx,
		input logic has_next, input logic indirect, input logic [IDX_W-1:0] nxt);
		if (!calm && $urandom_range(0, 7) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.opcode        <= op;
		req_ch.desc_index    <= idx;
		req_ch.link_has_next <= has_next;
		req_ch.link_indirect <= indirect;
		req_ch.link_next     <= nxt;
		if (op == OP_SETLINK) begin
			link_shadow[idx] = '{indirect: indirect, has_next: has_next, next: nxt};
			link_known[idx] = 1'b1;
		end
		items_sent++;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Request whose link fields are noise.
	task automatic issue_op(input logic [2:0] op, input logic [IDX_W-1:0] idx);
		issue(op, idx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rnd_idx());
	endtask

	// Write missing link entries until the walk from head touches only written ones.
	task automatic free_chain(input logic [IDX_W-1:0] head);
		logic [IDX_W-1:0] i;
		int unsigned      s;
		bit               fixed;
		do begin
			fixed = 1'b0;
			i = head;
			if (!link_known[i]) begin
				issue(OP_SETLINK, i, 1'b0, 1'($urandom_range(0, 1)), rnd_idx());
				fixed = 1'b1;
			end else if (!link_shadow[i].indirect) begin
				for (s = 0; s < active_q && !fixed; s++) begin
					if (!link_known[i]) begin
						issue(OP_SETLINK, i, 1'b0, 1'($urandom_range(0, 1)), rnd_idx());
						fixed = 1'b1;
					end else if (!link_shadow[i].has_next) begin
						break;
					end else begin
						i = link_shadow[i].next;
					end
				end
			end
		end while (fixed);
		issue_op(OP_CHAIN, head);
	endtask

	// Typical use: take k descriptors, link them into a chain, give them back.
	task automatic chain_sequence();
		int unsigned      k;
		int unsigned      tries;
		logic [IDX_W-1:0] v;
		logic [IDX_W-1:0] ids [$];
		bit               taken [MAX_DESC];
		k = ($urandom_range(0, 15) == 0) ? $urandom_range(1, active_q) :
			$urandom_range(1, (active_q < 8) ? active_q : 8);
		repeat (k) issue_op(OP_ALLOC, rnd_idx());
		for (int j = 0; j < k; j++) begin
			tries = 0;
			do begin
				v = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, active_q - 1)) :
					rnd_idx();
				tries++;
			end while (taken[v] && tries < 8);
			taken[v] = 1'b1;
			ids.push_back(v);
		end
		for (int j = 0; j < k; j++) begin
			if (j == k - 1) begin
				// close the chain, now and then back onto itself
				if ($urandom_range(0, 11) == 0) begin
					issue(OP_SETLINK, ids[j], 1'b1, 1'($urandom_range(0, 1)),
						ids[$urandom_range(0, j)]);
				end else begin
					issue(OP_SETLINK, ids[j], 1'b0, (j == 0) && ($urandom_range(0, 7) == 0),
						rnd_idx());
				end
			end else begin
				issue(OP_SETLINK, ids[j], 1'b1, (j == 0) ? ($urandom_range(0, 7) == 0) :
					1'($urandom_range(0, 1)), ids[j + 1]);
			end
		end
		if ($urandom_range(0, 4) == 0) begin
			foreach (ids[j]) issue_op(OP_FREE, ids[j]);
		end else begin
			free_chain(ids[0]);
		end
	endtask

	task automatic random_step();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: chain_sequence();
			6: issue_op(OP_ALLOC, rnd_idx());
			7: issue_op(OP_FREE, rnd_idx());
			8: free_chain(rnd_idx());
			default: begin
				case ($urandom_range(0, 2))
					0: issue(OP_SETLINK, rnd_idx(), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), rnd_idx());
					1: issue_op(OP_REINIT, rnd_idx());
					default: issue_op(3'($urandom_range(OP_REINIT + 1, OP_TOP_CODE)), rnd_idx());
				endcase
			end
		endcase
	endtask

	// Drop valid and wait until every expected response has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	task automatic write_size(input logic [CNT_W-1:0] v);
		drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		active_q = (v == '0) ? 1 : ((v > CNT_W'(MAX_DESC)) ? MAX_DESC : v);
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] v, input int unsigned n);
		int unsigned target;
		write_size(v);
		target = items_sent + n;
		while (items_sent < target) random_step();
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		req_ch.valid         = 1'b0;
		req_ch.opcode        = OP_ALLOC;
		req_ch.desc_index    = '0;
		req_ch.link_has_next = 1'b0;
		req_ch.link_indirect = 1'b0;
		req_ch.link_next     = '0;
		rsp_ch.ready         = 1'b0;
		for (int i = 0; i < MAX_DESC; i++) begin
			link_known[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset size, full stack, empty links
		issue_op(OP_ALLOC, 8'd255);
		issue_op(OP_ALLOC, 8'd0);
		issue_op(OP_FREE, 8'd255);
		issue_op(OP_FREE, 8'd0);
		issue_op(OP_FREE, 8'd7);
		// two entries pointing at each other: walk runs into the bound
		issue(OP_SETLINK, 8'd255, 1'b1, 1'b0, 8'd0);
		issue(OP_SETLINK, 8'd0, 1'b1, 1'b0, 8'd255);
		repeat (3) issue_op(OP_ALLOC, 8'd0);
		free_chain(8'd0);
		// indirect head, then the same on a full stack
		issue(OP_SETLINK, 8'd16, 1'b1, 1'b1, 8'd32);
		issue(OP_SETLINK, 8'd32, 1'b0, 1'b0, 8'd0);
		issue_op(OP_ALLOC, 8'd0);
		free_chain(8'd16);
		free_chain(8'd16);
		free_chain(8'd32);
		repeat (2) issue_op(OP_ALLOC, 8'd0);
		free_chain(8'd255);
		for (logic [2:0] op = OP_REINIT + 1; op != OP_ALLOC; op++) begin
			issue_op(op, rnd_idx());
		end
		issue_op(OP_ALLOC, 8'd0);
		issue_op(OP_REINIT, 8'd0);

		// Random phases over a range of queue sizes
		run_phase(9'd1, 200);
		run_phase(9'd0, 200);
		run_phase(9'd8, 200);
		run_phase(9'd511, 200);
		run_phase(9'd2, 200);
		run_phase(CNT_W'($urandom_range(3, 64)), 200);
		run_phase(9'd257, 200);
		run_phase(CNT_W'($urandom_range(65, 255)), 200);
		run_phase(9'd16, 200);
		calm = 1'b1;
		run_phase(9'd256, 200);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
